[hdl/nvmt_pkg.sv]
// Package for the nearest value match table: word layout, register codes, sizes.
// No dependencies; used by nvmt_cell and nearest_value_match_table_core.
`timescale 1ns / 1ps
`default_nettype none

package nvmt_pkg;

  localparam int unsigned NVMT_TABLE_DEPTH = 1024;
  localparam int unsigned ID_W             = 32;
  localparam int unsigned STRENGTH_W       = 30;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned CFG_INDEX_W      = 1;

  localparam logic [ID_W-1:0]       FOUNDER_ID_RESET       = 32'd1;
  localparam logic [STRENGTH_W-1:0] FOUNDER_STRENGTH_RESET = 30'd1000000000;

  localparam logic [CFG_INDEX_W-1:0] REG_FOUNDER_ID       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOUNDER_STRENGTH = 1'b1;

  // Query word travelling down the chain with its best match so far.
  typedef struct packed {
    logic                  valid;
    logic [ID_W-1:0]       id;
    logic [STRENGTH_W-1:0] strength;
    logic [STRENGTH_W-1:0] best_d;
    logic [STRENGTH_W-1:0] best_s;
    logic [ID_W-1:0]       best_id;
  } query_t;

  function automatic logic [STRENGTH_W-1:0] distance(
    input logic [STRENGTH_W-1:0] a,
    input logic [STRENGTH_W-1:0] b
  );
    distance = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

[hdl/nvmt_cell.sv]
// One table cell: holds one stored entry and one stage of the query chain.
// Depends on nvmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvmt_cell
  import nvmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = NVMT_TABLE_DEPTH,
  parameter int unsigned CELL_INDEX  = 0,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire query_t           query_in,
  input  wire logic [CNT_W-1:0] slot_in,
  output query_t                query_out,
  output logic [CNT_W-1:0]      slot_out
);

  localparam logic [CNT_W-1:0] CELL_SLOT = CNT_W'(CELL_INDEX);

  logic [STRENGTH_W-1:0] entry_strength;
  logic [ID_W-1:0]       entry_id;
  query_t                query_q;
  query_t                query_next;
  logic [CNT_W-1:0]      slot_q;
  logic [STRENGTH_W-1:0] d;
  logic                  active;
  logic                  take;
  logic                  store;

  assign active = slot_in > CELL_SLOT;
  assign store  = advance && query_in.valid && (slot_in == CELL_SLOT);
  assign d      = distance(query_in.strength, entry_strength);
  assign take   = active && ((d < query_in.best_d) ||
                             ((d == query_in.best_d) && (entry_strength < query_in.best_s)));

  always_comb begin
    query_next = query_in;
    if (take) begin
      query_next.best_d  = d;
      query_next.best_s  = entry_strength;
      query_next.best_id = entry_id;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      entry_strength <= query_in.strength;
      entry_id       <= query_in.id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_q.valid <= 1'b0;
    end else if (advance) begin
      query_q <= query_next;
      slot_q  <= slot_in;
    end
  end

  assign query_out = query_q;
  assign slot_out  = slot_q;

endmodule

`default_nettype wire

[hdl/nearest_value_match_table_core.sv]
// Top level of the nearest value match table: founder registers, fill count, cell chain.
// Depends on nvmt_pkg and nvmt_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_ready  | new_id, strength
// out      | output    | out_valid / out_ready| added_id, match_id, table_full
// cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// A word passes down the cell chain and is registered in each cell while the chain advances.
// A new word enters every cycle while the chain advances.
// The chain advances unless the last stage holds a word that out_ready does not take;
// a stall on out freezes every stage and drops in_ready.
// Reset empties the chain and the table and loads the founder defaults; no clearing pass.

module nearest_value_match_table_core
  import nvmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = NVMT_TABLE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ID_W-1:0]        new_id,
  input  wire logic [STRENGTH_W-1:0]  strength,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ID_W-1:0]             added_id,
  output logic [ID_W-1:0]             match_id,
  output logic                        table_full,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  logic [ID_W-1:0]       founder_id;
  logic [STRENGTH_W-1:0] founder_strength;
  logic [CNT_W-1:0]      entry_count;
  logic                  advance;
  logic                  accept;

  query_t           query [0:TABLE_DEPTH];
  logic [CNT_W-1:0] slot  [0:TABLE_DEPTH];

  assign advance = !query[TABLE_DEPTH].valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      founder_id       <= FOUNDER_ID_RESET;
      founder_strength <= FOUNDER_STRENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOUNDER_ID:       founder_id       <= cfg_data[ID_W-1:0];
        REG_FOUNDER_STRENGTH: founder_strength <= cfg_data[STRENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && (entry_count != FULL_COUNT)) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  always_comb begin
    query[0].valid    = in_valid;
    query[0].id       = new_id;
    query[0].strength = strength;
    query[0].best_d   = distance(strength, founder_strength);
    query[0].best_s   = founder_strength;
    query[0].best_id  = founder_id;
    slot[0]           = entry_count;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    nvmt_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .query_in  (query[k]),
      .slot_in   (slot[k]),
      .query_out (query[k+1]),
      .slot_out  (slot[k+1])
    );
  end

  assign out_valid  = query[TABLE_DEPTH].valid;
  assign added_id   = query[TABLE_DEPTH].id;
  assign match_id   = query[TABLE_DEPTH].best_id;
  assign table_full = slot[TABLE_DEPTH] == FULL_COUNT;

endmodule

`default_nettype wire
